// ===== sv/hsv_to_rgb_pixel_formatter_assert.svh =====
// Assertion macros for the pixel formatter.
// Compile with ASSERT_OFF defined to drop every check.
`ifndef HSV_TO_RGB_PIXEL_FORMATTER_ASSERT_SVH
`define HSV_TO_RGB_PIXEL_FORMATTER_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define HSVFMT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hsvfmt assertion failed");

// condition must never be true outside reset
`define HSVFMT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("hsvfmt forbidden condition seen");

`else

`define HSVFMT_ASSERT(lbl, clk, rst, prop)
`define HSVFMT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== sv/hsvfmt_pkg.sv =====
`default_nettype none

package hsvfmt_pkg;

   // field widths
   localparam int CHAN_W  = 8;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam int OFF_W   = 6;
   localparam int PROD_W  = 16;
   localparam int RAMP_W  = 14;
   localparam int RECIP_W = 15;
   localparam int SCALE_W = 28;

   // strip limit, effective count saturates here
   localparam logic [COUNT_W-1:0] MAX_PIXELS = 11'd1024;

   // configuration register indexes
   localparam logic CSR_COLOR_ORDER = 1'b0;
   localparam logic CSR_PIXEL_COUNT = 1'b1;

   // wire byte orders
   localparam logic ORDER_RGB = 1'b0;
   localparam logic ORDER_GRB = 1'b1;

   // input channel meaning
   localparam logic MODE_HSV = 1'b0;
   localparam logic MODE_RGB = 1'b1;

   // hue sector starts
   localparam logic [CHAN_W-1:0] HUE_START_1 = 8'd43;
   localparam logic [CHAN_W-1:0] HUE_START_2 = 8'd85;
   localparam logic [CHAN_W-1:0] HUE_START_3 = 8'd128;
   localparam logic [CHAN_W-1:0] HUE_START_4 = 8'd171;
   localparam logic [CHAN_W-1:0] HUE_START_5 = 8'd213;
   localparam logic [CHAN_W-1:0] CHAN_FULL   = 8'd255;

   // hue sectors: which component ramps and in which direction
   localparam logic [2:0] SEC_G_UP   = 3'd0;
   localparam logic [2:0] SEC_R_DOWN = 3'd1;
   localparam logic [2:0] SEC_B_UP   = 3'd2;
   localparam logic [2:0] SEC_G_DOWN = 3'd3;
   localparam logic [2:0] SEC_R_UP   = 3'd4;
   localparam logic [2:0] SEC_B_DOWN = 3'd5;

   // x/43 and x/42 as (x * ceil(2^20/d)) >> 20, exact for x below 27594
   localparam int                 RECIP_SHIFT = 20;
   localparam logic [RECIP_W-1:0] RECIP_43    = 15'd24386;
   localparam logic [RECIP_W-1:0] RECIP_42    = 15'd24967;

   // control that travels alongside the color data
   typedef struct packed {
      logic               valid;
      logic               mode;
      logic               en;
      logic [INDEX_W-1:0] idx;
   } hsvfmt_side_type;

endpackage

`default_nettype wire

// ===== sv/hsv_to_rgb_pixel_formatter.sv =====
// An accepted item passes pipeline stages 1 to 4 and then the output register before rsp_strobe is high.
// Throughput: one item per cycle; four pipeline stages plus an output register.
// busy is never high and results are never held: the receiver cannot stall.
// Reset (synchronous, active high) clears the pipeline valid bits,
// color_order and pixel_count; items in flight are dropped.
`default_nettype none

`include "hsv_to_rgb_pixel_formatter_assert.svh"

module hsv_to_rgb_pixel_formatter
   import hsvfmt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // item input
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_mode,
   input  wire logic [INDEX_W-1:0] req_pixel_index,
   input  wire logic [CHAN_W-1:0]  req_chan_a,
   input  wire logic [CHAN_W-1:0]  req_chan_b,
   input  wire logic [CHAN_W-1:0]  req_chan_c,
   // result output
   output logic                    rsp_strobe,
   output logic                    rsp_write_enable,
   output logic      [INDEX_W-1:0] rsp_out_index,
   output logic      [CHAN_W-1:0]  rsp_byte_first,
   output logic      [CHAN_W-1:0]  rsp_byte_second,
   output logic      [CHAN_W-1:0]  rsp_byte_third,
   // configuration writes
   input  wire logic               csr_write_enable,
   input  wire logic               csr_index,
   input  wire logic [COUNT_W-1:0] csr_write_data
);

   // configuration registers
   logic               color_order_ff;
   logic [COUNT_W-1:0] pixel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_order_ff <= ORDER_RGB;
         pixel_count_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COLOR_ORDER: color_order_ff <= csr_write_data[0];
            CSR_PIXEL_COUNT: pixel_count_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // never stalls
   assign busy = 1'b0;

   // strip bounds check at entry, count saturated to the strip limit
   logic [COUNT_W-1:0] count_eff;
   hsvfmt_side_type    in_side;

   assign count_eff     = (pixel_count_ff > MAX_PIXELS) ? MAX_PIXELS : pixel_count_ff;
   assign in_side.valid = start && !busy;
   assign in_side.mode  = req_mode;
   assign in_side.en    = {1'b0, req_pixel_index} < count_eff;
   assign in_side.idx   = req_pixel_index;

   hsvfmt_side_type   pipe_side;
   logic [CHAN_W-1:0] pipe_red, pipe_green, pipe_blue;

   hsvfmt_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_side   (in_side),
      .in_a      (req_chan_a),
      .in_b      (req_chan_b),
      .in_c      (req_chan_c),
      .out_side  (pipe_side),
      .out_red   (pipe_red),
      .out_green (pipe_green),
      .out_blue  (pipe_blue)
   );

   // output register: wire byte order, zero bytes for rejected writes
   logic               strobe_ff;
   logic               wen_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [CHAN_W-1:0]  first_ff, second_ff, third_ff;
   logic [CHAN_W-1:0]  first_in, second_in, third_in;

   always_comb begin
      if (!pipe_side.en) begin
         first_in  = '0;
         second_in = '0;
         third_in  = '0;
      end else if (color_order_ff == ORDER_GRB) begin
         first_in  = pipe_green;
         second_in = pipe_red;
         third_in  = pipe_blue;
      end else begin
         first_in  = pipe_red;
         second_in = pipe_green;
         third_in  = pipe_blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= pipe_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      wen_ff    <= pipe_side.en;
      index_ff  <= pipe_side.idx;
      first_ff  <= first_in;
      second_ff <= second_in;
      third_ff  <= third_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_write_enable = wen_ff;
   assign rsp_out_index    = index_ff;
   assign rsp_byte_first   = first_ff;
   assign rsp_byte_second  = second_ff;
   assign rsp_byte_third   = third_ff;

   // every accepted item comes out on rsp_strobe after the pipeline and output register
   `HSVFMT_ASSERT(a_item_out, clock, reset, (start && !busy) |-> ##5 rsp_strobe)
   // no result without an earlier accepted item
   `HSVFMT_ASSERT(a_no_extra, clock, reset, rsp_strobe |-> $past(start && !busy, 5))
   // rejected writes carry zero bytes
   `HSVFMT_NEVER(a_reject_zero, clock, reset, rsp_strobe && !rsp_write_enable && (rsp_byte_first != 8'd0 || rsp_byte_second != 8'd0 || rsp_byte_third != 8'd0))

endmodule

`default_nettype wire

// ===== sv/hsvfmt_pipe.sv =====
`default_nettype none

// Four register stages of HSV to RGB conversion, final ramp add after stage four.
module hsvfmt_pipe
   import hsvfmt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hsvfmt_side_type   in_side,
   input  wire logic [CHAN_W-1:0] in_a,
   input  wire logic [CHAN_W-1:0] in_b,
   input  wire logic [CHAN_W-1:0] in_c,
   output hsvfmt_side_type        out_side,
   output logic      [CHAN_W-1:0] out_red,
   output logic      [CHAN_W-1:0] out_green,
   output logic      [CHAN_W-1:0] out_blue
);

   // stage 1: sector decode, V*(255-S)
   hsvfmt_side_type    s1_side_ff;
   logic [2:0]         s1_sector_ff, s1_sector_in;
   logic [OFF_W-1:0]   s1_off_ff, s1_off_in;
   logic [PROD_W-1:0]  s1_prod_ff;
   logic [CHAN_W-1:0]  s1_a_ff, s1_b_ff, s1_v_ff;
   logic [CHAN_W-1:0]  hue_base;

   always_comb begin
      if (in_a < HUE_START_1) begin
         s1_sector_in = SEC_G_UP;
         hue_base     = '0;
      end else if (in_a < HUE_START_2) begin
         s1_sector_in = SEC_R_DOWN;
         hue_base     = HUE_START_1;
      end else if (in_a < HUE_START_3) begin
         s1_sector_in = SEC_B_UP;
         hue_base     = HUE_START_2;
      end else if (in_a < HUE_START_4) begin
         s1_sector_in = SEC_G_DOWN;
         hue_base     = HUE_START_3;
      end else if (in_a < HUE_START_5) begin
         s1_sector_in = SEC_R_UP;
         hue_base     = HUE_START_4;
      end else begin
         s1_sector_in = SEC_B_DOWN;
         hue_base     = HUE_START_5;
      end
   end

   logic [CHAN_W-1:0] hue_off;
   assign hue_off   = in_a - hue_base;
   assign s1_off_in = hue_off[OFF_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff <= '0;
      end else begin
         s1_side_ff <= in_side;
      end
   end

   always_ff @(posedge clock) begin
      s1_sector_ff <= s1_sector_in;
      s1_off_ff    <= s1_off_in;
      s1_prod_ff   <= PROD_W'(in_c) * PROD_W'(CHAN_FULL - in_b);
      s1_a_ff      <= in_a;
      s1_b_ff      <= in_b;
      s1_v_ff      <= in_c;
   end

   // stage 2: min = prod/255 as (x + (x>>8) + 1) >> 8, span = max - min
   hsvfmt_side_type    s2_side_ff;
   logic [2:0]         s2_sector_ff;
   logic [OFF_W-1:0]   s2_off_ff;
   logic [CHAN_W-1:0]  s2_mn_ff, s2_mx_ff, s2_d_ff, s2_a_ff, s2_b_ff;
   logic [PROD_W:0]    div_sum;
   logic [CHAN_W-1:0]  s2_mn_in;

   assign div_sum  = {1'b0, s1_prod_ff} + {9'd0, s1_prod_ff[PROD_W-1:CHAN_W]} + 17'd1;
   assign s2_mn_in = div_sum[PROD_W-1:CHAN_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_side_ff <= '0;
      end else begin
         s2_side_ff <= s1_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_sector_ff <= s1_sector_ff;
      s2_off_ff    <= s1_off_ff;
      s2_mn_ff     <= s2_mn_in;
      s2_mx_ff     <= s1_v_ff;
      s2_d_ff      <= s1_v_ff - s2_mn_in;
      s2_a_ff      <= s1_a_ff;
      s2_b_ff      <= s1_b_ff;
   end

   // stage 3: span * offset
   hsvfmt_side_type    s3_side_ff;
   logic [2:0]         s3_sector_ff;
   logic [RAMP_W-1:0]  s3_ramp_ff;
   logic [CHAN_W-1:0]  s3_mn_ff, s3_mx_ff, s3_a_ff, s3_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_side_ff <= '0;
      end else begin
         s3_side_ff <= s2_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_sector_ff <= s2_sector_ff;
      s3_ramp_ff   <= RAMP_W'(s2_d_ff) * RAMP_W'(s2_off_ff);
      s3_mn_ff     <= s2_mn_ff;
      s3_mx_ff     <= s2_mx_ff;
      s3_a_ff      <= s2_a_ff;
      s3_b_ff      <= s2_b_ff;
   end

   // stage 4: multiply by reciprocal of 42 or 43
   hsvfmt_side_type    s4_side_ff;
   logic [2:0]         s4_sector_ff;
   logic [SCALE_W-1:0] s4_scale_ff;
   logic [CHAN_W-1:0]  s4_mn_ff, s4_mx_ff, s4_a_ff, s4_b_ff;
   logic [RECIP_W-1:0] recip;
   logic [RAMP_W+RECIP_W-1:0] scale_full;

   assign recip      = (s3_sector_ff inside {SEC_R_DOWN, SEC_R_UP}) ? RECIP_42 : RECIP_43;
   assign scale_full = (RAMP_W+RECIP_W)'(s3_ramp_ff) * (RAMP_W+RECIP_W)'(recip);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_side_ff <= '0;
      end else begin
         s4_side_ff <= s3_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_sector_ff <= s3_sector_ff;
      s4_scale_ff  <= scale_full[SCALE_W-1:0];
      s4_mn_ff     <= s3_mn_ff;
      s4_mx_ff     <= s3_mx_ff;
      s4_a_ff      <= s3_a_ff;
      s4_b_ff      <= s3_b_ff;
   end

   // quotient, ramp up from min or down from max, place by sector
   logic [CHAN_W-1:0] quot, rise, fall;

   assign quot = s4_scale_ff[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
   assign rise = s4_mn_ff + quot;
   assign fall = s4_mx_ff - quot;

   always_comb begin
      if (s4_side_ff.mode == MODE_RGB) begin
         out_red   = s4_a_ff;
         out_green = s4_b_ff;
         out_blue  = s4_mx_ff;
      end else begin
         case (s4_sector_ff)
            SEC_G_UP: begin
               out_red = s4_mx_ff; out_green = rise;     out_blue = s4_mn_ff;
            end
            SEC_R_DOWN: begin
               out_red = fall;     out_green = s4_mx_ff; out_blue = s4_mn_ff;
            end
            SEC_B_UP: begin
               out_red = s4_mn_ff; out_green = s4_mx_ff; out_blue = rise;
            end
            SEC_G_DOWN: begin
               out_red = s4_mn_ff; out_green = fall;     out_blue = s4_mx_ff;
            end
            SEC_R_UP: begin
               out_red = rise;     out_green = s4_mn_ff; out_blue = s4_mx_ff;
            end
            default: begin
               out_red = s4_mx_ff; out_green = s4_mn_ff; out_blue = fall;
            end
         endcase
      end
   end

   assign out_side = s4_side_ff;

endmodule

`default_nettype wire
